// File: rtl/vtsg_pkg.sv
// shared constants, types and font table for the value to glyph word stream block
// no dependencies; compiled first
package vtsg_pkg;

   localparam int MAX_DIGITS      = 5;
   localparam int MAX_GLYPHS      = MAX_DIGITS + 1;
   localparam int VALUE_W         = 16;
   localparam int COUNT_W         = 3;
   localparam int POS_W           = 3;
   localparam int GLYPH_W         = 5;
   localparam int WORD_W          = 64;
   localparam int WORD_BYTES      = 8;
   localparam int WORDS_PER_GLYPH = 8;
   localparam int GLYPHS          = 19;
   localparam int FONT_BYTES      = 52;
   localparam int FONT_BITS       = FONT_BYTES * 8;
   localparam int DIV_W           = 14;
   localparam int SHIFT_W         = DIV_W + VALUE_W - 1;
   localparam int STEP_W          = $clog2(VALUE_W);
   localparam int GIDX_W          = $clog2(MAX_GLYPHS);
   localparam int WIDX_W          = $clog2(WORDS_PER_GLYPH);

   localparam logic REQ_VALUE = 1'b0;
   localparam logic REQ_GLYPH = 1'b1;

   localparam logic [GLYPH_W-1:0] DIGIT_MAX   = 5'd9;
   localparam logic [GLYPH_W-1:0] GLYPH_POINT = 5'd11;
   localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 5'd19;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   localparam logic [DIV_W-1:0] TENS [0:MAX_DIGITS-1] = '{
      14'd1, 14'd10, 14'd100, 14'd1000, 14'd10000
   };

   // font bytes in display order, first byte in the top bits
   localparam logic [FONT_BITS-1:0] FONT [0:GLYPHS-1] = '{
      {96'hFC7FFF1FF93FFE4FF31FFC67, 96'h070000700700007007000070,
       96'h070000700700007007000070, 96'h07000070F31FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'h000000000000000000000000, 96'h000000000000000000000000,
       96'h000000000000000000000000, 96'h00000000F01FFC07F83FFE0F, 32'hFC7FFF1F},
      {96'h0000FF1F0100FE4F0380FC67, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39F0060F93F0040, 32'hFC7F0000},
      {96'h000000000100004003800060, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'hFC7F0000F83F0000F09F0000, 96'h00C0010000C0010000C00100,
       96'h00C0010000C0010000C00100, 96'h00C00100F09FFC07F83FFE0F, 32'hFC7FFF1F},
      {96'hFC7F0000F93F0040F39F0060, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C001700380FC670100FE4F, 32'h0000FF1F},
      {96'hFC7FFF1FF93FFE4FF39FFC67, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C001700380FC670100FE4F, 32'h0000FF1F},
      {96'hFC7F0000F93F0000F31F0000, 96'h070000000700000007000000,
       96'h070000000700000007000000, 96'h07000000F31FFC07F93FFE0F, 32'hFC7FFF1F},
      {96'hFC7FFF1FF93FFE4FF39FFC67, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'hFC7F0000F93F0040F39F0060, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'h000000000000000000000000, 96'h00000000001F7C00001F7C00,
       96'h001F7C00001F7C00001F7C00, 96'h000000000000000000000000, 32'h00000000},
      {96'h000000000000000000000000, 96'h000000000000007C0000007C,
       96'h0000007C0000007C0000007C, 96'h000000000000000000000000, 32'h00000000},
      {96'h000000000000000000800000, 96'h00C0010000C0010000C00100,
       96'h00C0010000C0010000C00100, 96'h00C001000080000000000000, 32'h00000000},
      {96'h000000000080000000C00100, 96'h00C0010000C0010000FC1F00,
       96'h00FE3F0000FC1F0000C00100, 96'h00C0010000C0010000800000, 32'h00000000},
      {96'hFC7FFF1FF83FFE4FF09FFC67, 96'h00C0017000C0017000C00170,
       96'h00C0017000C0017000C00170, 96'h00C001700080FC670000FE4F, 32'h0000FF1F},
      {96'h0000FF1F0000FE4F0080FC67, 96'h00C0017000C0017000C00170,
       96'h00C0017000C0017000C00170, 96'h00C00170F09FFC67F83FFE4F, 32'hFC7FFF1F},
      {96'hFC7FFF1FF93FFE0FF31FFC07, 96'h0700000007000000E71F0000,
       96'hF73F0000E71F000007000000, 96'h07000000F31FFC07F93FFE0F, 32'hFC7FFF1F},
      {96'hFC7FFF1FF83FFE0FF09FFC07, 96'h00C0010000C0010000C00100,
       96'h00C0010000C0010000C00100, 96'h00C00100F09FFC07F83FFE0F, 32'hFC7FFF1F},
      {96'h000000000000004000800060, 96'h00C0017600C0817700C0E173,
       96'h00C0F97100C07D7000C01D70, 96'h00C001700080006000000040, 32'h00000000}
   };

   // one display word of a glyph; unknown glyphs and the tail bytes read as zero
   function automatic logic [WORD_W-1:0] font_word(input logic [GLYPH_W-1:0] glyph,
                                                   input logic [WIDX_W-1:0]  word_idx);
      logic [WORD_W-1:0] word;
      int                idx;
      word = '0;
      for (int b = 0; b < WORD_BYTES; b++) begin
         idx = int'(word_idx) * WORD_BYTES + b;
         if (glyph < GLYPH_W'(GLYPHS) && idx < FONT_BYTES) begin
            word[8*b +: 8] = FONT[glyph][FONT_BITS-8-8*idx +: 8];
         end
      end
      return word;
   endfunction

endpackage

// File: rtl/vtsg_req_if.sv
// request channel: valid/ready handshake with one print or glyph request
// depends on vtsg_pkg
interface vtsg_req_if import vtsg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [VALUE_W-1:0] value;
   logic [COUNT_W-1:0] digit_count;
   logic [POS_W-1:0]   decimal_pos;
   logic [GLYPH_W-1:0] glyph_code;

   modport source (output valid, req_type, value, digit_count, decimal_pos, glyph_code,
                   input ready);
   modport sink   (input valid, req_type, value, digit_count, decimal_pos, glyph_code,
                   output ready);
endinterface

// File: rtl/vtsg_rsp_if.sv
// response channel: valid/ready handshake carrying one display word
// depends on vtsg_pkg
interface vtsg_rsp_if import vtsg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] column_bytes;
   logic              last_word;
   logic              overflow;

   modport source (output valid, column_bytes, last_word, overflow, input ready);
   modport sink   (input valid, column_bytes, last_word, overflow, output ready);
endinterface

// File: rtl/value_to_segment_glyph_stream_top.sv
// value to glyph word stream: decimal conversion, glyph list and font word output
// depends on vtsg_pkg, vtsg_req_if, vtsg_rsp_if
//
// req_chan takes one request per handshake: either a 16-bit value with a digit
// count and decimal position, or a single glyph code. rsp_chan returns eight
// 64-bit display words per glyph, last_word marking the final word of a request.
// a value is split into digits by a shared shift-and-subtract unit, one quotient
// bit per cycle, from the top digit position down; after the last digit, as
// straight after a glyph request is taken, the sequencer enters word output and
// then loads the first word into a single output register. words then leave at
// one per cycle while rsp_chan does not stall; a request yields up to 48 words.
// a digit count of zero is accepted and yields no word.
// req_chan.ready is high only while no request is in flight; the last word may
// still be waiting in the output register when the next request is taken.
// if rsp_chan stalls, the held word stays put and the sequencer waits.
// reset is synchronous: the sequencer returns to idle and the output empties.
module value_to_segment_glyph_stream_top import vtsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   vtsg_req_if.sink   req_chan,
   vtsg_rsp_if.source rsp_chan
);

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [SHIFT_W-1:0] dsh_ff, dsh_in;
   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   dec_ff, dec_in;
   logic               shown_ff, shown_in;
   logic               ovf_ff, ovf_in;
   logic [GLYPH_W-1:0] glyph_ff [MAX_GLYPHS];
   logic [GLYPH_W-1:0] glyph_in [MAX_GLYPHS];
   logic [GIDX_W-1:0]  ng_ff, ng_in;
   logic [GIDX_W-1:0]  gi_ff, gi_in;
   logic [WIDX_W-1:0]  wi_ff, wi_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               ge;
   logic [VALUE_W-1:0] val_next;
   logic [VALUE_W-1:0] quot_next;
   logic               digit_big;
   logic [GLYPH_W-1:0] digit;
   logic               at_dec;
   logic               shown_next;
   logic               digit_done;
   logic [COUNT_W-1:0] cnt_clamp;
   logic [POS_W-1:0]   start_pos;
   logic [POS_W-1:0]   pos_dn;
   logic [GIDX_W-1:0]  ng_plus1;
   logic               word_last;
   logic               load;

   // shared compare and subtract against the shifted power of ten
   assign ge         = {(SHIFT_W-VALUE_W)'(0), val_ff} >= dsh_ff;
   assign val_next   = ge ? (val_ff - dsh_ff[VALUE_W-1:0]) : val_ff;
   assign quot_next  = {quot_ff[VALUE_W-2:0], ge};
   assign digit_big  = quot_next > VALUE_W'(DIGIT_MAX);
   assign digit      = digit_big ? DIGIT_MAX : quot_next[GLYPH_W-1:0];
   assign at_dec     = pos_ff == dec_ff;
   assign shown_next = shown_ff | (quot_next != '0) | at_dec;
   assign digit_done = step_ff == STEP_W'(VALUE_W-1);

   assign cnt_clamp = (req_chan.digit_count > COUNT_W'(MAX_DIGITS)) ?
                      COUNT_W'(MAX_DIGITS) : req_chan.digit_count;
   assign start_pos = POS_W'(cnt_clamp - COUNT_W'(1));
   assign pos_dn    = pos_ff - POS_W'(1);
   assign ng_plus1  = ng_ff + GIDX_W'(1);

   assign word_last = (gi_ff == ng_ff - GIDX_W'(1)) &&
                      (wi_ff == WIDX_W'(WORDS_PER_GLYPH-1));
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      dec_in   = dec_ff;
      shown_in = shown_ff;
      ovf_in   = ovf_ff;
      glyph_in = glyph_ff;
      ng_in    = ng_ff;
      gi_in    = gi_ff;
      wi_in    = wi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               ovf_in = 1'b0;
               gi_in  = '0;
               wi_in  = '0;
               if (req_chan.req_type == REQ_GLYPH) begin
                  glyph_in[0] = req_chan.glyph_code;
                  ng_in       = GIDX_W'(1);
                  state_in    = ST_EMIT;
               end else if (cnt_clamp != '0) begin
                  val_in   = req_chan.value;
                  dec_in   = req_chan.decimal_pos;
                  pos_in   = start_pos;
                  dsh_in   = {TENS[start_pos], (VALUE_W-1)'(0)};
                  quot_in  = '0;
                  step_in  = '0;
                  shown_in = 1'b0;
                  ng_in    = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            val_in  = val_next;
            quot_in = quot_next;
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (digit_done) begin
               shown_in        = shown_next;
               ovf_in          = ovf_ff | digit_big;
               glyph_in[ng_ff] = shown_next ? digit : GLYPH_BLANK;
               ng_in           = ng_plus1;
               if (dec_ff != '0 && at_dec) begin
                  glyph_in[ng_plus1] = GLYPH_POINT;
                  ng_in              = ng_plus1 + GIDX_W'(1);
               end
               if (pos_ff == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  pos_in  = pos_dn;
                  dsh_in  = {TENS[pos_dn], (VALUE_W-1)'(0)};
                  quot_in = '0;
                  step_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               wi_in = wi_ff + WIDX_W'(1);
               if (wi_ff == WIDX_W'(WORDS_PER_GLYPH-1)) begin
                  gi_in = gi_ff + GIDX_W'(1);
               end
               if (word_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = font_word(glyph_ff[gi_ff], wi_ff);
         rsp_last_in  = word_last;
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      dsh_ff      <= dsh_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      pos_ff      <= pos_in;
      dec_ff      <= dec_in;
      shown_ff    <= shown_in;
      ovf_ff      <= ovf_in;
      glyph_ff    <= glyph_in;
      ng_ff       <= ng_in;
      gi_ff       <= gi_in;
      wi_ff       <= wi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_chan.ready        = state_ff == ST_IDLE;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.column_bytes = rsp_data_ff;
   assign rsp_chan.last_word    = rsp_last_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

   // remainder ends below the power of ten of the finished position
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && digit_done) |->
         val_next < {(VALUE_W-DIV_W)'(0), TENS[pos_ff]})
      else $error("remainder not below divisor");

   // word output only ever walks a non-empty glyph list, inside its bounds
   a_emit_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (ng_ff != '0 && gi_ff < ng_ff))
      else $error("glyph index outside list");

   // the sequencer leaves word output only on the last word of the run
   a_emit_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("run ended without last word");

endmodule

// File: dv/tb_value_to_segment_glyph_stream_top.sv
`timescale 1ns / 100ps
// testbench for value_to_segment_glyph_stream_top: drives print and glyph requests,
// predicts every display word from its own font table and digit split, checks in order
// depends on vtsg_pkg, vtsg_req_if, vtsg_rsp_if and the block under test
module tb_value_to_segment_glyph_stream_top import vtsg_pkg::*; ();

   localparam int CYCLE_LIMIT  = 1_200_000;
   localparam int SETTLE_WAIT  = 200;
   localparam int HOLD_OFF_LEN = 400;
   localparam int REPORT_MAX   = 10;
   localparam int FONT_GLYPHS  = 19;
   localparam int FONT_LEN     = 52;
   localparam int FONT_W       = FONT_LEN * 8;

   localparam logic [GLYPH_W-1:0] GLYPH_ZERO     = 5'd0;
   localparam logic [GLYPH_W-1:0] GLYPH_COLON    = 5'd10;
   localparam logic [GLYPH_W-1:0] GLYPH_MINUS    = 5'd12;
   localparam logic [GLYPH_W-1:0] GLYPH_Z        = 5'd18;
   localparam logic [GLYPH_W-1:0] GLYPH_CODE_TOP = 5'd31;

   typedef struct packed {
      logic               req_type;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] digit_count;
      logic [POS_W-1:0]   decimal_pos;
      logic [GLYPH_W-1:0] glyph_code;
   } print_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] column_bytes;
      logic              last_word;
      logic              overflow;
   } display_word_type;

   // font bytes, earliest byte in the top bits
   localparam logic [FONT_W-1:0] glyph_font [0:FONT_GLYPHS-1] = '{
      {96'hFC7FFF1FF93FFE4FF31FFC67, 96'h070000700700007007000070,
       96'h070000700700007007000070, 96'h07000070F31FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'h000000000000000000000000, 96'h000000000000000000000000,
       96'h000000000000000000000000, 96'h00000000F01FFC07F83FFE0F, 32'hFC7FFF1F},
      {96'h0000FF1F0100FE4F0380FC67, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39F0060F93F0040, 32'hFC7F0000},
      {96'h000000000100004003800060, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'hFC7F0000F83F0000F09F0000, 96'h00C0010000C0010000C00100,
       96'h00C0010000C0010000C00100, 96'h00C00100F09FFC07F83FFE0F, 32'hFC7FFF1F},
      {96'hFC7F0000F93F0040F39F0060, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C001700380FC670100FE4F, 32'h0000FF1F},
      {96'hFC7FFF1FF93FFE4FF39FFC67, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C001700380FC670100FE4F, 32'h0000FF1F},
      {96'hFC7F0000F93F0000F31F0000, 96'h070000000700000007000000,
       96'h070000000700000007000000, 96'h07000000F31FFC07F93FFE0F, 32'hFC7FFF1F},
      {96'hFC7FFF1FF93FFE4FF39FFC67, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'hFC7F0000F93F0040F39F0060, 96'h07C0017007C0017007C00170,
       96'h07C0017007C0017007C00170, 96'h07C00170F39FFC67F93FFE4F, 32'hFC7FFF1F},
      {96'h000000000000000000000000, 96'h00000000001F7C00001F7C00,
       96'h001F7C00001F7C00001F7C00, 96'h000000000000000000000000, 32'h00000000},
      {96'h000000000000000000000000, 96'h000000000000007C0000007C,
       96'h0000007C0000007C0000007C, 96'h000000000000000000000000, 32'h00000000},
      {96'h000000000000000000800000, 96'h00C0010000C0010000C00100,
       96'h00C0010000C0010000C00100, 96'h00C001000080000000000000, 32'h00000000},
      {96'h000000000080000000C00100, 96'h00C0010000C0010000FC1F00,
       96'h00FE3F0000FC1F0000C00100, 96'h00C0010000C0010000800000, 32'h00000000},
      {96'hFC7FFF1FF83FFE4FF09FFC67, 96'h00C0017000C0017000C00170,
       96'h00C0017000C0017000C00170, 96'h00C001700080FC670000FE4F, 32'h0000FF1F},
      {96'h0000FF1F0000FE4F0080FC67, 96'h00C0017000C0017000C00170,
       96'h00C0017000C0017000C00170, 96'h00C00170F09FFC67F83FFE4F, 32'hFC7FFF1F},
      {96'hFC7FFF1FF93FFE0FF31FFC07, 96'h0700000007000000E71F0000,
       96'hF73F0000E71F000007000000, 96'h07000000F31FFC07F93FFE0F, 32'hFC7FFF1F},
      {96'hFC7FFF1FF83FFE0FF09FFC07, 96'h00C0010000C0010000C00100,
       96'h00C0010000C0010000C00100, 96'h00C00100F09FFC07F83FFE0F, 32'hFC7FFF1F},
      {96'h000000000000004000800060, 96'h00C0017600C0817700C0E173,
       96'h00C0F97100C07D7000C01D70, 96'h00C001700080006000000040, 32'h00000000}
   };

   logic clock = 1'b0;
   logic reset;

   vtsg_req_if req_chan ();
   vtsg_rsp_if rsp_chan ();

   value_to_segment_glyph_stream_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   display_word_type pending_words [$];
   display_word_type expected_word;
   display_word_type seen_word;
   int               error_count      = 0;
   bit               tx_gaps_on       = 1'b1;
   bit               rx_stalls_on     = 1'b1;
   bit               hold_off_request = 1'b0;
   int               stall_left       = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] glyph_word(input logic [GLYPH_W-1:0] code,
                                                    input int                 word_idx);
      logic [WORD_W-1:0] acc;
      int                idx;
      acc = '0;
      if (code < FONT_GLYPHS) begin
         for (int b = 0; b < 8; b++) begin
            idx = word_idx * 8 + b;
            if (idx < FONT_LEN) begin
               acc[8*b +: 8] = glyph_font[code][FONT_W-8-8*idx +: 8];
            end
         end
      end
      return acc;
   endfunction

   task automatic predict_display_words(input print_req_type r);
      logic [GLYPH_W-1:0] glyph_seq [0:2*MAX_DIGITS-1];
      int                 n_glyphs;
      int                 n_pos;
      int                 pos;
      int unsigned        rem;
      int unsigned        q;
      int unsigned        divisor;
      logic               ovf;
      logic               lit;
      display_word_type   w;
      n_glyphs = 0;
      ovf      = 1'b0;
      lit      = 1'b0;
      if (r.req_type == REQ_GLYPH) begin
         glyph_seq[0] = r.glyph_code;
         n_glyphs     = 1;
      end else begin
         n_pos = (r.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(r.digit_count);
         rem   = r.value;
         for (pos = n_pos - 1; pos >= 0; pos--) begin
            divisor = 1;
            repeat (pos) divisor = divisor * 10;
            q   = rem / divisor;
            rem = rem % divisor;
            if (q != 0) lit = 1'b1;
            // top digit capped
            if (q > DIGIT_MAX) begin
               q   = DIGIT_MAX;
               ovf = 1'b1;
            end
            if (pos == r.decimal_pos) lit = 1'b1;
            glyph_seq[n_glyphs] = lit ? GLYPH_W'(q) : GLYPH_BLANK;
            n_glyphs++;
            if (r.decimal_pos != 0 && pos == r.decimal_pos) begin
               glyph_seq[n_glyphs] = GLYPH_POINT;
               n_glyphs++;
            end
         end
      end
      for (int k = 0; k < n_glyphs; k++) begin
         for (int wi = 0; wi < WORDS_PER_GLYPH; wi++) begin
            w.column_bytes = glyph_word(glyph_seq[k], wi);
            w.last_word    = (k == n_glyphs - 1) && (wi == WORDS_PER_GLYPH - 1);
            w.overflow     = ovf;
            pending_words.push_back(w);
         end
      end
   endtask

   function automatic print_req_type value_request(input int value, input int count,
                                                   input int dec);
      print_req_type r;
      r             = '0;
      r.req_type    = REQ_VALUE;
      r.value       = VALUE_W'(value);
      r.digit_count = COUNT_W'(count);
      r.decimal_pos = POS_W'(dec);
      return r;
   endfunction

   function automatic print_req_type glyph_request(input logic [GLYPH_W-1:0] code);
      print_req_type r;
      r            = '0;
      r.req_type   = REQ_GLYPH;
      r.glyph_code = code;
      return r;
   endfunction

   function automatic print_req_type random_request();
      print_req_type r;
      int            cnt;
      r.req_type = ($urandom_range(0, 9) < 3) ? REQ_GLYPH : REQ_VALUE;
      // spread magnitudes so leading blanks show up often
      r.value = VALUE_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
      cnt     = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
      r.digit_count = COUNT_W'(cnt);
      if ($urandom_range(0, 3) == 0 || cnt == 0) begin
         r.decimal_pos = POS_W'($urandom_range(0, 7));
      end else begin
         r.decimal_pos = POS_W'($urandom_range(0, cnt - 1));
      end
      r.glyph_code = ($urandom_range(0, 7) == 0) ? GLYPH_W'($urandom_range(20, 31))
                                                 : GLYPH_W'($urandom_range(0, 19));
      return r;
   endfunction

   task automatic send_request(input print_req_type r);
      if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= r.req_type;
      req_chan.value       <= r.value;
      req_chan.digit_count <= r.digit_count;
      req_chan.decimal_pos <= r.decimal_pos;
      req_chan.glyph_code  <= r.glyph_code;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_display_words(r);
   endtask

   task automatic wait_for_drain();
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   task automatic test_directed_values();
      send_request(value_request(65535, 5, 0));
      send_request(value_request(0, 5, 0));
      send_request(value_request(0, 3, 2));
      send_request(value_request(12345, 3, 0));
      send_request(value_request(500, 7, 1));
      send_request(value_request(42, 0, 0));
      send_request(value_request(0, 2, 4));
      send_request(value_request(65535, 1, 0));
      send_request(value_request(7, 5, 7));
      send_request(value_request(1234, 4, 3));
      send_request(value_request(9, 1, 1));
      send_request(value_request(100, 5, 5));
   endtask

   task automatic test_directed_glyphs();
      send_request(glyph_request(GLYPH_ZERO));
      send_request(glyph_request(GLYPH_COLON));
      send_request(glyph_request(GLYPH_POINT));
      send_request(glyph_request(GLYPH_MINUS));
      send_request(glyph_request(GLYPH_Z));
      send_request(glyph_request(GLYPH_BLANK));
      send_request(glyph_request(GLYPH_CODE_TOP));
   endtask

   task automatic test_random_mix(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 25 == 0) begin
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
         end
         send_request(random_request());
      end
   endtask

   task automatic test_backpressure(input int n);
      tx_gaps_on       = 1'b0;
      hold_off_request = 1'b1;
      for (int i = 0; i < n; i++) send_request(random_request());
      tx_gaps_on = 1'b1;
   endtask

   task automatic test_pause_and_resume(input int n);
      for (int i = 0; i < n; i++) send_request(random_request());
      req_chan.valid <= 1'b0;
      wait_for_drain();
      for (int i = 0; i < n; i++) send_request(random_request());
   endtask

   task automatic test_steady_stream(input int n);
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      for (int i = 0; i < n; i++) send_request(random_request());
   endtask

   // receiver side: random stalls plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left       = HOLD_OFF_LEN - 1;
            rsp_chan.ready <= 1'b0;
         end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // each accepted word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen_word.column_bytes = rsp_chan.column_bytes;
         seen_word.last_word    = rsp_chan.last_word;
         seen_word.overflow     = rsp_chan.overflow;
         if (pending_words.size() == 0) begin
            if (error_count < REPORT_MAX) begin
               $display("unexpected word: bytes %h last %b ovf %b",
                        seen_word.column_bytes, seen_word.last_word, seen_word.overflow);
            end
            error_count++;
         end else begin
            expected_word = pending_words.pop_front();
            if (seen_word.column_bytes !== expected_word.column_bytes ||
                seen_word.last_word !== expected_word.last_word ||
                seen_word.overflow !== expected_word.overflow) begin
               if (error_count < REPORT_MAX) begin
                  $display({"word mismatch: exp bytes %h last %b ovf %b,",
                            " got bytes %h last %b ovf %b"},
                           expected_word.column_bytes, expected_word.last_word,
                           expected_word.overflow, seen_word.column_bytes,
                           seen_word.last_word, seen_word.overflow);
               end
               error_count++;
            end
         end
      end
   end

   initial begin
      for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_VALUE;
      req_chan.value       = '0;
      req_chan.digit_count = '0;
      req_chan.decimal_pos = '0;
      req_chan.glyph_code  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_values();
      test_directed_glyphs();
      test_random_mix(130);
      test_backpressure(20);
      test_pause_and_resume(10);
      test_steady_stream(110);

      req_chan.valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (pending_words.size() != 0) begin
         $display("%0d words never arrived", pending_words.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
